/* hw/rtl/md5_pkg.sv */
// md5_pkg: shared types, constants and tables for the MD5 digest engine.
// Used by md5_front, md5_cmd_fifo, md5_back and md5_digest_engine.
package md5_pkg;

  localparam int CMD_FIFO_DEPTH = 4;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'd128;
  localparam logic [5:0]  LEN_OFFSET = 6'd56;
  localparam logic [5:0]  LAST_POS = 6'd63;
  localparam logic [5:0]  LAST_STEP = 6'd63;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic       has_byte;
    logic       is_end;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_COMPRESS,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } pad_phase_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Per-step rotate amount.
  function automatic logic [4:0] md5_rot(input logic [1:0] rnd, input logic [1:0] j);
    logic [4:0] r;
    case ({rnd, j})
      4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
      4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
      4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'hA: r = 5'd16;  4'hB: r = 5'd23;
      4'hC: r = 5'd6;   4'hD: r = 5'd10;  4'hE: r = 5'd15;  4'hF: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Message word used by a step.
  function automatic logic [3:0] md5_word_sel(input logic [5:0] step);
    logic [3:0] j;
    logic [3:0] g;
    j = step[3:0];
    case (step[5:4])
      2'd0: g = j;
      2'd1: g = j * 4'd5 + 4'd1;
      2'd2: g = j * 4'd3 + 4'd5;
      2'd3: g = j * 4'd7;
      default: g = j;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/md5_digest_engine.sv */
// md5_digest_engine: streaming MD5 digest, top level.
// Depends on md5_pkg, md5_front, md5_cmd_fifo, md5_back.

// Bytes stream in one item at a time; the front end drops idle items and
// queues the rest, so it keeps taking items while the back end compresses
// until the queue fills. The back end packs one byte per cycle while the queue
// holds items and runs one MD5 step per cycle in a single round unit: a full
// 64-byte block is packed, then compressed in 64 steps and the chaining add.
// An end marker makes it add the padding bytes (up to 64, or 72 when the
// length spills into an extra block), compress each padded block, then emit
// words A, B, C, D in turn, waiting while the consumer stalls. The engine
// returns to the initial chaining values once word D is loaded for output.
module md5_digest_engine #(
  parameter int FIFO_DEPTH = md5_pkg::CMD_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  md5_pkg::cmd_t push_cmd;
  md5_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  md5_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .fifo_full      (full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  md5_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  md5_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

/* hw/rtl/md5_front.sv */
// md5_front: input stage; takes items, drops idle ones, holds one command.
// Depends on md5_pkg (cmd_t).
module md5_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic           byte_valid,
  input  logic           end_of_message,
  input  logic           fifo_full,
  output logic           push,
  output md5_pkg::cmd_t  push_cmd
);

  logic          hold_valid;
  md5_pkg::cmd_t hold;

  assign push     = hold_valid && !fifo_full;
  assign in_ready = !hold_valid || !fifo_full;
  assign push_cmd = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      // items with neither a byte nor an end mark do nothing
      hold_valid <= byte_valid || end_of_message;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold.has_byte <= byte_valid;
      hold.is_end   <= end_of_message;
      hold.data     <= data_byte;
    end
  end

endmodule

/* hw/rtl/md5_cmd_fifo.sv */
// md5_cmd_fifo: short command queue between front end and back end.
// Depends on md5_pkg (cmd_t).
module md5_cmd_fifo #(
  parameter int DEPTH = md5_pkg::CMD_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  md5_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output md5_pkg::cmd_t  head,
  output logic           full,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  md5_pkg::cmd_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue underflow");
  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst) !(full && empty))
    else $error("command queue both full and empty");

endmodule

/* hw/rtl/md5_back.sv */
// md5_back: block packing, MD5 round unit, padding sequencer, digest output.
// Depends on md5_pkg (types, K table, rotate and word select functions).
module md5_back (
  input  logic           clk,
  input  logic           rst,
  input  md5_pkg::cmd_t  head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    digest_word,
  output logic [1:0]     word_index,
  output logic           last_word
);

  md5_pkg::back_state_t state, state_next;
  md5_pkg::pad_phase_t  phase;

  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [5:0]  pos;
  logic [63:0] bit_length;
  logic [63:0] len_snap;
  logic [2:0]  len_k;
  logic [5:0]  step;
  logic [1:0]  emit_idx;
  logic [31:0] a, b, c, d;

  logic        pb_en;
  logic [7:0]  pb_data;
  logic        out_load;

  // round unit
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [31:0] b_new;

  always_comb begin
    case (step[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum      = a + f + md5_pkg::K_TABLE[step] + blk[md5_pkg::md5_word_sel(step)];
    rot_wide = {sum, sum} << md5_pkg::md5_rot(step[5:4], step[1:0]);
    b_new    = b + rot_wide[63:32];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      md5_pkg::ST_FETCH: begin
        if (!empty) begin
          if (head.has_byte && pos == md5_pkg::LAST_POS) begin
            state_next = md5_pkg::ST_COMPRESS;
          end else if (head.is_end) begin
            state_next = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_COMPRESS: begin
        if (step == md5_pkg::LAST_STEP) begin
          state_next = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        if (phase == md5_pkg::PH_DONE) begin
          state_next = md5_pkg::ST_EMIT;
        end else if (phase == md5_pkg::PH_NONE) begin
          state_next = md5_pkg::ST_FETCH;
        end else begin
          state_next = md5_pkg::ST_PAD;
        end
      end
      md5_pkg::ST_PAD: begin
        if (pos == md5_pkg::LAST_POS) begin
          state_next = md5_pkg::ST_COMPRESS;
        end
      end
      md5_pkg::ST_EMIT: begin
        if (out_load && emit_idx == 2'd3) begin
          state_next = md5_pkg::ST_FETCH;
        end
      end
      default: state_next = md5_pkg::ST_FETCH;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    pb_en    = 1'b0;
    pb_data  = head.data;
    out_load = 1'b0;
    case (state)
      md5_pkg::ST_FETCH: begin
        pop   = !empty;
        pb_en = !empty && head.has_byte;
      end
      md5_pkg::ST_PAD: begin
        pb_en = 1'b1;
        case (phase)
          md5_pkg::PH_MARK: pb_data = md5_pkg::PAD_MARK;
          md5_pkg::PH_LEN:  pb_data = len_snap[{len_k, 3'b000} +: 8];
          default:          pb_data = 8'h00;
        endcase
      end
      md5_pkg::ST_EMIT: begin
        out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5_pkg::ST_FETCH;
    end else begin
      state <= state_next;
    end
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= md5_pkg::PH_NONE;
      pos        <= '0;
      bit_length <= '0;
      len_k      <= '0;
      step       <= '0;
      emit_idx   <= '0;
      out_valid  <= 1'b0;
      chain[0]   <= md5_pkg::INIT_A;
      chain[1]   <= md5_pkg::INIT_B;
      chain[2]   <= md5_pkg::INIT_C;
      chain[3]   <= md5_pkg::INIT_D;
    end else begin
      if (pb_en) begin
        pos <= pos + 6'd1;
        if (pos == md5_pkg::LAST_POS) begin
          step <= '0;
        end
      end
      if (pop) begin
        if (head.has_byte) begin
          bit_length <= bit_length + 64'd8;
        end
        if (head.is_end) begin
          phase <= md5_pkg::PH_MARK;
          len_k <= '0;
        end
      end
      if (state == md5_pkg::ST_PAD) begin
        if (phase == md5_pkg::PH_LEN) begin
          len_k <= len_k + 3'd1;
          if (len_k == 3'd7) begin
            phase <= md5_pkg::PH_DONE;
          end
        end else if (pos + 6'd1 == md5_pkg::LEN_OFFSET) begin
          phase <= md5_pkg::PH_LEN;
        end else begin
          phase <= md5_pkg::PH_ZERO;
        end
      end
      if (state == md5_pkg::ST_COMPRESS) begin
        step <= step + 6'd1;
      end
      if (state == md5_pkg::ST_ADD) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        emit_idx <= emit_idx + 2'd1;
        if (emit_idx == 2'd3) begin
          // digest words are already in the output path; start a new message
          phase      <= md5_pkg::PH_NONE;
          bit_length <= '0;
          chain[0]   <= md5_pkg::INIT_A;
          chain[1]   <= md5_pkg::INIT_B;
          chain[2]   <= md5_pkg::INIT_C;
          chain[3]   <= md5_pkg::INIT_D;
        end
      end
    end
  end

  // payload: block words, working variables, length snapshot, output register
  always_ff @(posedge clk) begin
    if (pb_en) begin
      blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= pb_data;
      if (pos == md5_pkg::LAST_POS) begin
        a <= chain[0];
        b <= chain[1];
        c <= chain[2];
        d <= chain[3];
      end
    end
    if (pop && head.is_end) begin
      len_snap <= head.has_byte ? bit_length + 64'd8 : bit_length;
    end
    if (state == md5_pkg::ST_COMPRESS) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_new;
    end
    if (out_load) begin
      digest_word <= chain[emit_idx];
      word_index  <= emit_idx;
      last_word   <= (emit_idx == 2'd3);
    end
  end

  a_compress_aligned: assert property (@(posedge clk) disable iff (rst)
      state == md5_pkg::ST_COMPRESS |-> pos == 6'd0)
    else $error("compression started off a block boundary");
  a_len_tail: assert property (@(posedge clk) disable iff (rst)
      (state == md5_pkg::ST_PAD && phase == md5_pkg::PH_LEN) |-> pos[5:3] == 3'b111)
    else $error("length bytes outside the block tail");
  a_done_emits: assert property (@(posedge clk) disable iff (rst)
      (state == md5_pkg::ST_ADD && phase == md5_pkg::PH_DONE) |=> state == md5_pkg::ST_EMIT)
    else $error("final block did not lead to digest output");
  a_last_is_d: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (last_word == (word_index == 2'd3)))
    else $error("last_word not on word D");

endmodule

/* tb/sv/md5_digest_engine_test.sv */
// md5_digest_engine_test: self-checking bench for the streaming MD5 engine.
// Feeds byte streams with end markers and checks each digest word against
// a built-in MD5 predictor. Needs md5_pkg and md5_digest_engine.
module md5_digest_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE_TICKS = 400;
  localparam int ITEM_TARGET  = 360;

  // rotate amounts, four per round
  localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                  4, 11, 16, 23, 6, 10, 15, 21};

  typedef struct {
    bit         pause;      // hold the sender until every digest is out
    logic [7:0] data;
    logic       has_byte;
    logic       is_end;
  } msg_item_t;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  md5_digest_engine DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  msg_item_t    pending[$];
  digest_word_t digest_expect[$];
  int           items_queued = 0;
  int           items_taken = 0;
  int           fail_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  logic [7:0]   stall_tick = 8'd0;
  logic [1:0]   stall_mode = 2'd0;

  // predictor state
  logic [31:0] md5_chain [4];
  logic [31:0] md5_block [16];
  logic [5:0]  md5_pos;
  logic [63:0] md5_bits;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic md5_restart();
    md5_chain[0] = md5_pkg::INIT_A;
    md5_chain[1] = md5_pkg::INIT_B;
    md5_chain[2] = md5_pkg::INIT_C;
    md5_chain[3] = md5_pkg::INIT_D;
    md5_pos = '0;
    md5_bits = '0;
  endtask

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int          g;
    int          rnd;
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl32(a + f + md5_pkg::K_TABLE[i] + md5_block[g], ROT_AMT[rnd * 4 + i % 4]);
      a = t;
    end
    md5_chain[0] += a;
    md5_chain[1] += b;
    md5_chain[2] += c;
    md5_chain[3] += d;
  endtask

  task automatic md5_put_byte(input logic [7:0] v);
    md5_block[md5_pos[5:2]][8 * md5_pos[1:0] +: 8] = v;
    md5_pos = md5_pos + 6'd1;
    if (md5_pos == 6'd0) md5_compress();
  endtask

  // absorb one accepted item; an end marker pads, finishes and queues A..D
  task automatic md5_absorb_item(input logic [7:0] data, input logic has_byte,
                                 input logic is_end);
    logic [63:0]  len;
    digest_word_t dw;
    if (has_byte) begin
      md5_put_byte(data);
      md5_bits = md5_bits + 64'd8;
    end
    if (is_end) begin
      len = md5_bits;
      md5_put_byte(md5_pkg::PAD_MARK);
      while (md5_pos != md5_pkg::LEN_OFFSET) md5_put_byte(8'h00);
      for (int k = 0; k < 8; k++) md5_put_byte(len[8 * k +: 8]);
      for (int k = 0; k < 4; k++) begin
        dw.word = md5_chain[k];
        dw.index = k[1:0];
        dw.last = (k == 3);
        digest_expect = {digest_expect, dw};
      end
      md5_restart();
    end
  endtask

  task automatic queue_item(input logic [7:0] data, input logic has_byte,
                            input logic is_end);
    msg_item_t it;
    it.pause = 1'b0;
    it.data = data;
    it.has_byte = has_byte;
    it.is_end = is_end;
    pending = {pending, it};
    items_queued++;
  endtask

  task automatic queue_pause();
    msg_item_t it;
    it.pause = 1'b1;
    it.data = 8'h00;
    it.has_byte = 1'b0;
    it.is_end = 1'b0;
    pending = {pending, it};
  endtask

  // one message with random content, idle items sprinkled in
  task automatic queue_message(input int len);
    int  body;
    logic carry;
    carry = (len > 0) && ($urandom_range(0, 1) == 1);
    body = carry ? len - 1 : len;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 7) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
      queue_item(8'($urandom), 1'b1, 1'b0);
    end
    queue_item(8'($urandom), carry, 1'b1);
  endtask

  initial begin
    int picked;
    int edge_lens [8];

    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
    md5_restart();

    // directed: idle, empty message, "abc", extreme bytes, end carrying a byte
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'hA5, 1'b0, 1'b1);
    queue_pause();
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(8'h5A, 1'b0, 1'b0);
    queue_item(8'h80, 1'b1, 1'b1);
    queue_item(8'hFF, 1'b1, 1'b1);
    queue_item(8'h00, 1'b1, 1'b1);
    queue_pause();

    while (items_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: picked = $urandom_range(0, 12);
        5, 6:          picked = edge_lens[$urandom_range(0, 5)];
        7:             picked = $urandom_range(40, 72);
        8:             picked = $urandom_range(0, 2);
        default:       picked = ($urandom_range(0, 2) == 0) ?
                                edge_lens[$urandom_range(6, 7)] : $urandom_range(1, 8);
      endcase
      queue_message(picked);
      repeat ($urandom_range(0, 2)) queue_item(8'($urandom), 1'b0, 1'b0);
      if ($urandom_range(0, 9) == 0) queue_pause();
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != items_queued || digest_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
    if (fail_count == 0) begin
      $display("md5_digest_engine verification clean");
    end else begin
      $display("md5_digest_engine verification failed");
    end
    $finish;
  end

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin : driver
    msg_item_t head;
    logic      drive_next;
    logic      nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      drive_next = 1'b1;
      if (in_valid && in_ready) begin
        md5_absorb_item(data_byte, byte_valid, end_of_message);
        items_taken <= items_taken + 1;
      end else if (in_valid) begin
        drive_next = 1'b0;
      end
      if (drive_next) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending.size() != 0) begin
          if (pending[0].pause) begin
            if (digest_expect.size() == 0) void'(pending.pop_front());
          end else begin
            head = pending.pop_front();
            data_byte <= head.data;
            byte_valid <= head.has_byte;
            end_of_message <= head.is_end;
            nxt_valid = 1'b1;
            if (burst_left <= 1) begin
              burst_left <= ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
              gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
              burst_left <= burst_left - 1;
            end
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // receiver: checks digest words, stalls on a mode picked when the low six bits of stall_tick wrap
  always @(posedge clk) begin : monitor
    digest_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_expect.size() == 0) begin
          $error("digest_word unexpected: got %h", digest_word);
          fail_count++;
        end else begin
          want = digest_expect.pop_front();
          if (digest_word !== want.word) begin
            $error("digest_word mismatch: expected %h, got %h", want.word, digest_word);
            fail_count++;
          end
          if (word_index !== want.index) begin
            $error("word_index mismatch: expected %0d, got %0d", want.index, word_index);
            fail_count++;
          end
          if (last_word !== want.last) begin
            $error("last_word mismatch: expected %0b, got %0b", want.last, last_word);
            fail_count++;
          end
        end
      end
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick[5:0] == 6'd63) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= 1'($urandom_range(0, 1));
        2'd2:    out_ready <= (stall_tick[2:0] == 3'd0);
        default: out_ready <= ~stall_tick[3];
      endcase
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("md5_digest_engine verification failed");
    $finish;
  end

endmodule
